### hdl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the segment intersection test
// orientation codes, touch kinds and the collinear threshold register format
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int unsigned THRESH_WIDTH = 16;
	localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd1;

	// orientation of a point against a directed segment
	typedef enum logic [1:0] {
		ORIENT_COLLINEAR = 2'd0,
		ORIENT_POS       = 2'd1,
		ORIENT_NEG       = 2'd2
	} orient_t;

	// kind of contact reported per request
	typedef enum logic [1:0] {
		TOUCH_NONE      = 2'd0,
		TOUCH_CROSS     = 2'd1,
		TOUCH_COLLINEAR = 2'd2
	} touch_t;

endpackage

### hdl/sit_orient.sv
// ----------------------------------------------------------------------------
// sit_orient: pipelined orientation determinant of three points
// differences, products, determinant and threshold code, one register each
// ----------------------------------------------------------------------------
module sit_orient #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                                  clk,
	input  logic signed [COORD_WIDTH-1:0]         ax,
	input  logic signed [COORD_WIDTH-1:0]         ay,
	input  logic signed [COORD_WIDTH-1:0]         bx,
	input  logic signed [COORD_WIDTH-1:0]         by,
	input  logic signed [COORD_WIDTH-1:0]         cx,
	input  logic signed [COORD_WIDTH-1:0]         cy,
	input  logic [sit_pkg::THRESH_WIDTH-1:0]      threshold,
	output sit_pkg::orient_t                      code
);

	localparam int DW   = COORD_WIDTH + 1;
	localparam int PW   = 2 * DW;
	localparam int DETW = PW + 1;

	logic signed [DW-1:0]   dy1_s2, dx2_s2, dx1_s2, dy2_s2;
	logic signed [PW-1:0]   prod_a, prod_b;
	logic signed [PW-1:0]   prod_a_s3, prod_b_s3;
	logic signed [DETW-1:0] det_s4;
	logic signed [DETW-1:0] thr_pos, thr_neg;
	logic                   below_thr;
	sit_pkg::orient_t       code_s5;

	// stage 2: coordinate differences
	always_ff @(posedge clk) begin
		dy1_s2 <= DW'(by) - DW'(ay);
		dx2_s2 <= DW'(cx) - DW'(bx);
		dx1_s2 <= DW'(bx) - DW'(ax);
		dy2_s2 <= DW'(cy) - DW'(by);
	end

	// stage 3: the two cross products
	assign prod_a = PW'(dy1_s2) * PW'(dx2_s2);
	assign prod_b = PW'(dx1_s2) * PW'(dy2_s2);

	always_ff @(posedge clk) begin
		prod_a_s3 <= prod_a;
		prod_b_s3 <= prod_b;
	end

	// stage 4: determinant
	always_ff @(posedge clk) begin
		det_s4 <= DETW'(prod_a_s3) - DETW'(prod_b_s3);
	end

	// stage 5: |det| < threshold, checked against +thr or -thr by sign
	assign thr_pos   = $signed(DETW'(threshold));
	assign thr_neg   = -thr_pos;
	assign below_thr = det_s4[DETW-1] ? (det_s4 > thr_neg) : (det_s4 < thr_pos);

	always_ff @(posedge clk) begin
		if (below_thr) begin
			code_s5 <= sit_pkg::ORIENT_COLLINEAR;
		end else if (det_s4[DETW-1]) begin
			code_s5 <= sit_pkg::ORIENT_NEG;
		end else begin
			code_s5 <= sit_pkg::ORIENT_POS;
		end
	end

	assign code = code_s5;

endmodule

### hdl/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_test: orientation-based segment intersection check
// ----------------------------------------------------------------------------
// usage:
//   a request is two segments (first start/end, second start/end), each point
//   signed Q12.8 on COORD_WIDTH bits. it is taken at a rising edge with start
//   high and busy low. busy never rises: the pipeline has no stall, so one
//   request per cycle is accepted, back to back without gaps.
//   the result (intersects, touch_kind) sits on its ports for one cycle,
//   marked by done, after the stage 1 capture, the orientation registers and
//   the stage 6 output register. results leave in request order.
//   the receiver cannot stall, so nothing here ever waits on the output side.
//   throughput is one request per cycle, set by the four orientation units,
//   each four registers deep behind the shared capture stage, with two
//   (COORD_WIDTH+1)-bit signed multipliers apiece.
//   collinear_threshold is written through cfg_we / cfg_wdata; write it only
//   while no request is in flight. reset (arst_n low) empties the pipeline
//   and sets the threshold to 1.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [COORD_WIDTH-1:0]      first_start_x,
	input  logic signed [COORD_WIDTH-1:0]      first_start_y,
	input  logic signed [COORD_WIDTH-1:0]      first_end_x,
	input  logic signed [COORD_WIDTH-1:0]      first_end_y,
	input  logic signed [COORD_WIDTH-1:0]      second_start_x,
	input  logic signed [COORD_WIDTH-1:0]      second_start_y,
	input  logic signed [COORD_WIDTH-1:0]      second_end_x,
	input  logic signed [COORD_WIDTH-1:0]      second_end_y,
	input  logic                               cfg_we,
	input  logic [sit_pkg::THRESH_WIDTH-1:0]   cfg_wdata,
	output logic                               done,
	output logic                               intersects,
	output logic [1:0]                         touch_kind
);

	// stage 1: captured request (a = first start, b = first end,
	// c = second start, d = second end)
	logic signed [COORD_WIDTH-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [COORD_WIDTH-1:0] cx_s1, cy_s1, dx_s1, dy_s1;

	// valid bit per stage, travels alongside the payload
	logic [6:1] valid_s;

	logic [sit_pkg::THRESH_WIDTH-1:0] threshold_q;

	// bounding-box flags: c and d in box(a,b), a and b in box(c,d)
	logic [3:0] box_now;
	logic [3:0] box_s2, box_s3, box_s4, box_s5;

	sit_pkg::orient_t d1_code, d2_code, d3_code, d4_code;

	logic            crossing, touch;
	sit_pkg::touch_t kind;
	logic            intersects_s6;
	sit_pkg::touch_t kind_s6;

	// inclusive range test without building min/max first
	function automatic logic in_range(
		input logic signed [COORD_WIDTH-1:0] p,
		input logic signed [COORD_WIDTH-1:0] e1,
		input logic signed [COORD_WIDTH-1:0] e2
	);
		in_range = ((e1 <= p) && (p <= e2)) || ((e2 <= p) && (p <= e1));
	endfunction

	// no back-pressure anywhere in the pipe
	assign busy = 1'b0;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= sit_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[5:1], start & ~busy};
		end
	end

	// stage 1: request capture
	always_ff @(posedge clk) begin
		ax_s1 <= first_start_x;
		ay_s1 <= first_start_y;
		bx_s1 <= first_end_x;
		by_s1 <= first_end_y;
		cx_s1 <= second_start_x;
		cy_s1 <= second_start_y;
		dx_s1 <= second_end_x;
		dy_s1 <= second_end_y;
	end

	// box tests run alongside the determinant pipeline
	assign box_now[0] = in_range(cx_s1, ax_s1, bx_s1) && in_range(cy_s1, ay_s1, by_s1);
	assign box_now[1] = in_range(dx_s1, ax_s1, bx_s1) && in_range(dy_s1, ay_s1, by_s1);
	assign box_now[2] = in_range(ax_s1, cx_s1, dx_s1) && in_range(ay_s1, cy_s1, dy_s1);
	assign box_now[3] = in_range(bx_s1, cx_s1, dx_s1) && in_range(by_s1, cy_s1, dy_s1);

	always_ff @(posedge clk) begin
		box_s2 <= box_now;
		box_s3 <= box_s2;
		box_s4 <= box_s3;
		box_s5 <= box_s4;
	end

	// four orientation units, codes ready at stage 5
	sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_d1 (
		.clk(clk), .ax(ax_s1), .ay(ay_s1), .bx(bx_s1), .by(by_s1),
		.cx(cx_s1), .cy(cy_s1), .threshold(threshold_q), .code(d1_code)
	);

	sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_d2 (
		.clk(clk), .ax(ax_s1), .ay(ay_s1), .bx(bx_s1), .by(by_s1),
		.cx(dx_s1), .cy(dy_s1), .threshold(threshold_q), .code(d2_code)
	);

	sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_d3 (
		.clk(clk), .ax(cx_s1), .ay(cy_s1), .bx(dx_s1), .by(dy_s1),
		.cx(ax_s1), .cy(ay_s1), .threshold(threshold_q), .code(d3_code)
	);

	sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_d4 (
		.clk(clk), .ax(cx_s1), .ay(cy_s1), .bx(dx_s1), .by(dy_s1),
		.cx(bx_s1), .cy(by_s1), .threshold(threshold_q), .code(d4_code)
	);

	// proper crossing: each segment's endpoints differ in code against the other;
	// a collinear code against a nonzero one also counts as differing
	assign crossing = (d1_code != d2_code) && (d3_code != d4_code);

	// collinear endpoint inside the other segment's box
	assign touch = ((d1_code == sit_pkg::ORIENT_COLLINEAR) && box_s5[0])
		|| ((d2_code == sit_pkg::ORIENT_COLLINEAR) && box_s5[1])
		|| ((d3_code == sit_pkg::ORIENT_COLLINEAR) && box_s5[2])
		|| ((d4_code == sit_pkg::ORIENT_COLLINEAR) && box_s5[3]);

	always_comb begin
		if (crossing) begin
			kind = sit_pkg::TOUCH_CROSS;
		end else if (touch) begin
			kind = sit_pkg::TOUCH_COLLINEAR;
		end else begin
			kind = sit_pkg::TOUCH_NONE;
		end
	end

	// stage 6: output register
	always_ff @(posedge clk) begin
		kind_s6       <= kind;
		intersects_s6 <= crossing | touch;
	end

	assign done       = valid_s[6];
	assign intersects = intersects_s6;
	assign touch_kind = kind_s6;

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for segment_intersection_test
// requests are pairs of segments in signed q12.8, fed with random gaps; each
// done strobe is compared against an orientation-based prediction made when
// the request was taken, under several collinear threshold settings
// ----------------------------------------------------------------------------
module tb;

	localparam int CW             = 20;
	localparam int COORD_MAX      = 524287;
	localparam int COORD_MIN      = -524288;
	localparam int TIMEOUT_CYCLES = 300000;
	localparam int DRAIN_CYCLES   = 12;

	// one request: two segments, first a->b, second c->d
	typedef struct {
		logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	} seg_pair_t;

	// flavors of random geometry
	typedef enum int {
		SHAPE_ANY,
		SHAPE_SMALL,
		SHAPE_ONLINE,
		SHAPE_SHARED,
		SHAPE_DEGEN,
		SHAPE_NEAR,
		SHAPE_EXTREME
	} shape_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic                               busy;
	logic signed [CW-1:0]               first_start_x = '0;
	logic signed [CW-1:0]               first_start_y = '0;
	logic signed [CW-1:0]               first_end_x = '0;
	logic signed [CW-1:0]               first_end_y = '0;
	logic signed [CW-1:0]               second_start_x = '0;
	logic signed [CW-1:0]               second_start_y = '0;
	logic signed [CW-1:0]               second_end_x = '0;
	logic signed [CW-1:0]               second_end_y = '0;
	logic                               cfg_we = 1'b0;
	logic [sit_pkg::THRESH_WIDTH-1:0]   cfg_wdata = '0;
	logic                               done;
	logic                               intersects;
	logic [1:0]                         touch_kind;

	// requests waiting for the driver, contacts waiting for done
	seg_pair_t       pending_pairs[$];
	sit_pkg::touch_t expected_contacts[$];

	// bench copy of the collinear threshold, follows every register write
	logic [sit_pkg::THRESH_WIDTH-1:0] thresh_copy = sit_pkg::THRESH_RESET;

	int  issued = 0;
	int  accepted = 0;
	int  mismatches = 0;
	int  cycles = 0;
	int  gap_left = 0;
	int  gap_pct = 0;
	bit  no_gaps = 1'b0;
	bit  req_taken = 1'b0;

	segment_intersection_test #(
		.COORD_WIDTH(CW)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.first_start_x  (first_start_x),
		.first_start_y  (first_start_y),
		.first_end_x    (first_end_x),
		.first_end_y    (first_end_y),
		.second_start_x (second_start_x),
		.second_start_y (second_start_y),
		.second_end_x   (second_end_x),
		.second_end_y   (second_end_y),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.intersects     (intersects),
		.touch_kind     (touch_kind)
	);

	// 10 unit period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// contact prediction
	// ------------------------------------------------------------------

	// side of point c against directed line a->b; the cross product needs
	// at most 43 bits, so a longint holds it exactly
	function automatic sit_pkg::orient_t side_of(longint ax, longint ay, longint bx,
			longint by, longint cx, longint cy, longint thresh);
		longint det;
		longint mag;
		det = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
		mag = (det < 0) ? -det : det;
		if (mag < thresh)
			return sit_pkg::ORIENT_COLLINEAR;
		return (det < 0) ? sit_pkg::ORIENT_NEG : sit_pkg::ORIENT_POS;
	endfunction

	// inclusive bounding box of segment (x1,y1)-(x2,y2)
	function automatic bit in_box(longint px, longint py, longint x1, longint y1,
			longint x2, longint y2);
		return px >= ((x1 < x2) ? x1 : x2) && px <= ((x1 < x2) ? x2 : x1)
			&& py >= ((y1 < y2) ? y1 : y2) && py <= ((y1 < y2) ? y2 : y1);
	endfunction

	function automatic sit_pkg::touch_t contact_of(seg_pair_t p, longint thresh);
		longint           ax, ay, bx, by, cx, cy, dx, dy;
		sit_pkg::orient_t s1, s2, s3, s4;
		ax = longint'(p.ax); ay = longint'(p.ay);
		bx = longint'(p.bx); by = longint'(p.by);
		cx = longint'(p.cx); cy = longint'(p.cy);
		dx = longint'(p.dx); dy = longint'(p.dy);
		s1 = side_of(ax, ay, bx, by, cx, cy, thresh);
		s2 = side_of(ax, ay, bx, by, dx, dy, thresh);
		s3 = side_of(cx, cy, dx, dy, ax, ay, thresh);
		s4 = side_of(cx, cy, dx, dy, bx, by, thresh);
		// a collinear code against a signed one still counts as differing
		if (s1 != s2 && s3 != s4)
			return sit_pkg::TOUCH_CROSS;
		if ((s1 == sit_pkg::ORIENT_COLLINEAR && in_box(cx, cy, ax, ay, bx, by))
				|| (s2 == sit_pkg::ORIENT_COLLINEAR && in_box(dx, dy, ax, ay, bx, by))
				|| (s3 == sit_pkg::ORIENT_COLLINEAR && in_box(ax, ay, cx, cy, dx, dy))
				|| (s4 == sit_pkg::ORIENT_COLLINEAR && in_box(bx, by, cx, cy, dx, dy)))
			return sit_pkg::TOUCH_COLLINEAR;
		return sit_pkg::TOUCH_NONE;
	endfunction

	// ------------------------------------------------------------------
	// geometry generators
	// ------------------------------------------------------------------

	function automatic int span(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic int corner_coord();
		case ($urandom_range(0, 5))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return span(COORD_MAX);
		endcase
	endfunction

	function automatic seg_pair_t pair_of(int ax, int ay, int bx, int by,
			int cx, int cy, int dx, int dy);
		seg_pair_t p;
		p.ax = CW'(ax); p.ay = CW'(ay); p.bx = CW'(bx); p.by = CW'(by);
		p.cx = CW'(cx); p.cy = CW'(cy); p.dx = CW'(dx); p.dy = CW'(dy);
		return p;
	endfunction

	function automatic seg_pair_t make_pair(shape_t shape);
		seg_pair_t p;
		int        ax, ay, ux, uy, t;
		case (shape)
			SHAPE_SMALL:
				p = pair_of(span(64), span(64), span(64), span(64),
					span(64), span(64), span(64), span(64));
			SHAPE_ONLINE: begin
				// points on one line (the second end sometimes random), second segment slides along the first
				ax = span(200000); ay = span(200000);
				ux = span(20000);  uy = span(20000);
				t  = span(5) + 2;
				p  = pair_of(ax, ay, ax + 4 * ux, ay + 4 * uy, ax + t * ux, ay + t * uy,
					ax + (span(5) + 2) * ux, ay + (span(5) + 2) * uy);
				if ($urandom_range(0, 2) == 0) begin
					p.dx = CW'(span(200000));
					p.dy = CW'(span(200000));
				end
			end
			SHAPE_SHARED: begin
				p = pair_of(span(200000), span(200000), span(200000), span(200000),
					0, 0, span(200000), span(200000));
				p.cx = $urandom_range(0, 1) ? p.ax : p.bx;
				p.cy = (p.cx == p.ax) ? p.ay : p.by;
			end
			SHAPE_DEGEN: begin
				// first segment collapsed to a point, sometimes on the second
				ax = span(200000); ay = span(200000);
				ux = span(20000);  uy = span(20000);
				if ($urandom_range(0, 1))
					p = pair_of(ax, ay, ax, ay, ax - ux, ay - uy, ax + ux, ay + uy);
				else
					p = pair_of(ax, ay, ax, ay, span(200000), span(200000),
						span(200000), span(200000));
				if ($urandom_range(0, 3) == 0) begin
					p.dx = p.cx;
					p.dy = p.cy;
				end
			end
			SHAPE_NEAR: begin
				// third point a hair off the line, straddles the threshold
				ax = span(200000); ay = span(200000);
				ux = span(400);    uy = span(400);
				t  = span(3) + 2;
				p  = pair_of(ax, ay, ax + 4 * ux, ay + 4 * uy,
					ax + t * ux + span(2), ay + t * uy + span(2),
					span(200000), span(200000));
			end
			SHAPE_EXTREME:
				p = pair_of(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
					corner_coord(), corner_coord(), corner_coord(), corner_coord());
			default:
				p = pair_of($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
		endcase
		// half the time swap the roles of the two segments
		if ($urandom_range(0, 1))
			p = pair_of(p.cx, p.cy, p.dx, p.dy, p.ax, p.ay, p.bx, p.by);
		return p;
	endfunction

	function automatic shape_t pick_shape();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 25) return SHAPE_ANY;
		if (roll < 40) return SHAPE_SMALL;
		if (roll < 60) return SHAPE_ONLINE;
		if (roll < 70) return SHAPE_SHARED;
		if (roll < 80) return SHAPE_DEGEN;
		if (roll < 92) return SHAPE_NEAR;
		return SHAPE_EXTREME;
	endfunction

	task automatic queue_random(int count);
		repeat (count) pending_pairs.push_back(make_pair(pick_shape()));
	endtask

	// ------------------------------------------------------------------
	// driver: one request per handshake, random idle bursts between them
	// ------------------------------------------------------------------

	task automatic drive_fields(seg_pair_t p);
		first_start_x  <= p.ax;
		first_start_y  <= p.ay;
		first_end_x    <= p.bx;
		first_end_y    <= p.by;
		second_start_x <= p.cx;
		second_start_y <= p.cy;
		second_end_x   <= p.dx;
		second_end_y   <= p.dy;
	endtask

	always @(negedge clk) begin
		seg_pair_t nxt;
		// only move on once the current request has been taken
		if (arst_n && (!start || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
				drive_fields(make_pair(SHAPE_ANY));
			end else if (pending_pairs.size() != 0 && !no_gaps
					&& $urandom_range(0, 99) < gap_pct) begin
				// burst of idle cycles, this one included; gap_left counts the rest
				gap_left = $urandom_range(0, 17);
				start <= 1'b0;
				drive_fields(make_pair(SHAPE_ANY));
			end else if (pending_pairs.size() != 0) begin
				// pop and count in one step so the sequencer never sees a gap
				nxt = pending_pairs.pop_front();
				issued++;
				start <= 1'b1;
				drive_fields(nxt);
			end else begin
				start <= 1'b0;
				drive_fields(make_pair(SHAPE_ANY));
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on accept, check on done, track register writes
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		sit_pkg::touch_t want;
		seg_pair_t       seen;
		if (!arst_n) begin
			thresh_copy <= sit_pkg::THRESH_RESET;
			req_taken   <= 1'b0;
		end else begin
			if (done) begin
				if (expected_contacts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cycle %0d: result with no request outstanding, got %0b %0d",
							cycles, intersects, touch_kind);
				end else begin
					want = expected_contacts.pop_front();
					if (intersects !== (want != sit_pkg::TOUCH_NONE) || touch_kind !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("cycle %0d: expected intersects %0b touch_kind %0d, got %0b %0d",
								cycles, want != sit_pkg::TOUCH_NONE, want, intersects,
								touch_kind);
					end
				end
			end
			req_taken <= start && !busy;
			if (start && !busy) begin
				seen = pair_of(int'(first_start_x), int'(first_start_y),
					int'(first_end_x), int'(first_end_y),
					int'(second_start_x), int'(second_start_y),
					int'(second_end_x), int'(second_end_y));
				expected_contacts.push_back(contact_of(seen, longint'(thresh_copy)));
				accepted++;
			end
			if (cfg_we)
				thresh_copy <= cfg_wdata;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------

	// idle means nothing queued, nothing on the port and nothing in flight
	task automatic wait_idle();
		while (!(pending_pairs.size() == 0 && issued == accepted
				&& expected_contacts.size() == 0))
			@(negedge clk);
	endtask

	task automatic write_threshold(logic [sit_pkg::THRESH_WIDTH-1:0] value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed requests under the reset threshold, q12.8 so 256 is one unit
		gap_pct = 20;
		// plain x crossing
		pending_pairs.push_back(pair_of(-256, -256, 256, 256, -256, 256, 256, -256));
		// parallel, apart
		pending_pairs.push_back(pair_of(0, 0, 512, 0, 0, 256, 512, 256));
		// far apart, no contact
		pending_pairs.push_back(pair_of(0, 0, 256, 256, 4096, 0, 4352, -256));
		// t junction: one collinear code against a signed one, still a crossing
		pending_pairs.push_back(pair_of(0, 0, 512, 0, 256, 0, 256, 512));
		// collinear overlap
		pending_pairs.push_back(pair_of(0, 0, 512, 0, 256, 0, 1024, 0));
		// collinear, disjoint
		pending_pairs.push_back(pair_of(0, 0, 512, 0, 768, 0, 1024, 0));
		// shared endpoint at an angle
		pending_pairs.push_back(pair_of(0, 0, 256, 256, 256, 256, 768, 0));
		// collinear touch exactly on the box corner
		pending_pairs.push_back(pair_of(0, 0, 256, 256, 256, 256, 512, 512));
		// collinear, one step beyond the box corner
		pending_pairs.push_back(pair_of(0, 0, 256, 256, 257, 257, 512, 512));
		// degenerate first segment lying on the second
		pending_pairs.push_back(pair_of(256, 0, 256, 0, 0, 0, 512, 0));
		// both segments the same point
		pending_pairs.push_back(pair_of(100, -100, 100, -100, 100, -100, 100, -100));
		// two distinct points
		pending_pairs.push_back(pair_of(100, 100, 100, 100, -100, 5, -100, 5));
		// full-range diagonals crossing
		pending_pairs.push_back(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
		// everything at the positive corner
		pending_pairs.push_back(pair_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		// everything at the negative corner
		pending_pairs.push_back(pair_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		// full-range collinear overlap along the bottom edge
		pending_pairs.push_back(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
			0, COORD_MIN, COORD_MAX, COORD_MIN));
		// near miss: third point one lsb off the line, |det| just at the threshold
		pending_pairs.push_back(pair_of(0, 0, 1, 0, 0, 1, 5, 9));
		pending_pairs.push_back(pair_of(0, 0, 2, 1, 1, 0, 1, 5));
		// long segments with tiny offset
		pending_pairs.push_back(pair_of(COORD_MIN, 0, COORD_MAX, 0, -1, 1, 1, -1));
		// mixed signs of codes on the second pair only
		pending_pairs.push_back(pair_of(0, 0, 512, 512, 256, 256, 512, 0));
		queue_random(50);
		wait_idle();

		// zero threshold: nothing is collinear
		write_threshold('0);
		gap_pct = 25;
		queue_random(100);
		wait_idle();

		// widest threshold, long stretch without idling
		write_threshold('1);
		gap_pct = 0;
		queue_random(100);
		wait_idle();

		write_threshold(16'd256);
		gap_pct = 40;
		queue_random(100);
		wait_idle();

		write_threshold(16'($urandom_range(2, 65534)));
		gap_pct = 15;
		queue_random(100);
		wait_idle();

		// back to the reset value, written explicitly
		write_threshold(sit_pkg::THRESH_RESET);
		gap_pct = 30;
		queue_random(100);
		wait_idle();

		// closing burst, back to back
		write_threshold(16'($urandom_range(0, 4096)));
		no_gaps = 1'b1;
		queue_random(90);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_contacts.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
hdl/sit_pkg.sv
hdl/sit_orient.sv
hdl/segment_intersection_test.sv
tb/sv/tb.sv
